### src/mfc4_pkg.sv
// ----------------------------------------------------------------------------
// mfc4_pkg
// Shared types, status codes and the CRC-16/Modbus byte update for the
// function 4 response checker.
// ----------------------------------------------------------------------------
package mfc4_pkg;

    // Verdict codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_SHORT = 3'd1;
    localparam logic [2:0] ST_ADDR  = 3'd2;
    localparam logic [2:0] ST_FUNC  = 3'd3;
    localparam logic [2:0] ST_COUNT = 3'd4;
    localparam logic [2:0] ST_CRC   = 3'd5;

    localparam int         MIN_FRAME      = 9;
    localparam logic [7:0] FC_READ_INPUT  = 8'h04;
    localparam logic [7:0] EXPECTED_COUNT = 8'h04;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Register map
    localparam int   APB_ADDR_W         = 3;
    localparam logic REG_IDX_SLAVE_ADDR = 1'b0;
    localparam logic [7:0] SLAVE_ADDR_RST = 8'h01;

    typedef struct packed {
        logic [15:0] type_word;
        logic [15:0] version_word;
        logic [2:0]  status;
    } mfc4_result_t;

    // One byte of CRC-16/Modbus, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### src/mfc4_apb_regs.sv
// ----------------------------------------------------------------------------
// mfc4_apb_regs
// APB register block holding the expected slave address.
// ----------------------------------------------------------------------------
module mfc4_apb_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mfc4_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [7:0]                      slave_address
);
    import mfc4_pkg::*;

    logic [7:0] slave_address_reg;
    logic [7:0] slave_address_next;
    logic       hit;
    logic       wr_en;

    assign pready = 1'b1;
    assign hit    = (paddr[2] == REG_IDX_SLAVE_ADDR);
    assign wr_en  = psel && penable && pwrite && pready && hit;

    always_comb
    begin
        slave_address_next = slave_address_reg;
        if (wr_en)
        begin
            slave_address_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= SLAVE_ADDR_RST;
        end
        else
        begin
            slave_address_reg <= slave_address_next;
        end
    end

    assign prdata        = hit ? {24'h000000, slave_address_reg} : 32'h00000000;
    assign slave_address = slave_address_reg;

endmodule

### src/mfc4_frame_check.sv
// ----------------------------------------------------------------------------
// mfc4_frame_check
// Per-frame state (CRC, byte position, two-byte lag, header fault, captured
// words) and the combinational verdict for the byte being consumed.
// ----------------------------------------------------------------------------
module mfc4_frame_check #(
    parameter int MAX_FRAME = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             rx_byte,
    input  logic                   last,
    input  logic [7:0]             slave_address,
    output mfc4_pkg::mfc4_result_t result
);
    import mfc4_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 1);

    logic [15:0]   crc_reg,        crc_next;
    logic [CW-1:0] count_reg,      count_next;
    logic [7:0]    lag0_reg,       lag0_next;
    logic [7:0]    lag1_reg,       lag1_next;
    logic [2:0]    header_bad_reg, header_bad_next;
    logic [15:0]   word0_reg,      word0_next;
    logic [15:0]   word1_reg,      word1_next;
    logic          taking;
    logic [2:0]    status;

    assign taking = (count_reg < CW'(MAX_FRAME));

    always_comb
    begin
        crc_next        = crc_reg;
        count_next      = count_reg;
        lag0_next       = lag0_reg;
        lag1_next       = lag1_reg;
        header_bad_next = header_bad_reg;
        word0_next      = word0_reg;
        word1_next      = word1_reg;
        if (taking)
        begin
            // the oldest lagged byte is known not to be CRC once a third arrives
            if (count_reg >= CW'(2))
            begin
                crc_next = crc16_byte(crc_reg, lag0_reg);
            end
            lag0_next  = lag1_reg;
            lag1_next  = rx_byte;
            count_next = count_reg + CW'(1);
            if (header_bad_reg == ST_OK)
            begin
                if (count_reg == CW'(0) && rx_byte != slave_address)
                begin
                    header_bad_next = ST_ADDR;
                end
                if (count_reg == CW'(1) && rx_byte != FC_READ_INPUT)
                begin
                    header_bad_next = ST_FUNC;
                end
                if (count_reg == CW'(2) && rx_byte != EXPECTED_COUNT)
                begin
                    header_bad_next = ST_COUNT;
                end
            end
            if (count_reg == CW'(3))
            begin
                word0_next = {rx_byte, 8'h00};
            end
            if (count_reg == CW'(4))
            begin
                word0_next = word0_reg | {8'h00, rx_byte};
            end
            if (count_reg == CW'(5))
            begin
                word1_next = {rx_byte, 8'h00};
            end
            if (count_reg == CW'(6))
            begin
                word1_next = word1_reg | {8'h00, rx_byte};
            end
        end
    end

    // verdict, judged on the state after this byte
    always_comb
    begin
        priority if (count_next < CW'(MIN_FRAME))
        begin
            status = ST_SHORT;
        end
        else if (header_bad_next != ST_OK)
        begin
            status = header_bad_next;
        end
        else if ({lag1_next, lag0_next} == crc_next)
        begin
            status = ST_OK;
        end
        else
        begin
            status = ST_CRC;
        end
    end

    assign result.status       = status;
    assign result.version_word = (status == ST_OK) ? word0_next : 16'h0000;
    assign result.type_word    = (status == ST_OK) ? word1_next : 16'h0000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= CRC_INIT;
            count_reg      <= '0;
            lag0_reg       <= 8'h00;
            lag1_reg       <= 8'h00;
            header_bad_reg <= ST_OK;
            word0_reg      <= 16'h0000;
            word1_reg      <= 16'h0000;
        end
        else if (step)
        begin
            if (last)
            begin
                crc_reg        <= CRC_INIT;
                count_reg      <= '0;
                lag0_reg       <= 8'h00;
                lag1_reg       <= 8'h00;
                header_bad_reg <= ST_OK;
                word0_reg      <= 16'h0000;
                word1_reg      <= 16'h0000;
            end
            else
            begin
                crc_reg        <= crc_next;
                count_reg      <= count_next;
                lag0_reg       <= lag0_next;
                lag1_reg       <= lag1_next;
                header_bad_reg <= header_bad_next;
                word0_reg      <= word0_next;
                word1_reg      <= word1_next;
            end
        end
    end

    a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        step && last |=> count_reg == '0 && crc_reg == CRC_INIT
                         && header_bad_reg == ST_OK)
        else $error("frame state not cleared after verdict");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_FRAME))
        else $error("byte position beyond frame limit");

endmodule

### src/modbus_fc4_response_checker.sv
// ----------------------------------------------------------------------------
// modbus_fc4_response_checker
// Checks a Modbus RTU function 4 response byte by byte and returns one
// verdict with the two register words at the end of each frame.
// ----------------------------------------------------------------------------
//  channel   dir   fields (low bit up)
//  s_*       in    tdata: rx_byte[7:0]; tlast: end_of_frame
//  m_*       out   tdata: status[2:0], version_word[18:3], type_word[34:19]
//  APB       in    0x0: slave_address[7:0] (reset 0x01)
//
// One byte per clock sustained; a byte passes an input register, then the
// CRC/header update and verdict logic into the result register (verdict
// registered as the last byte leaves the input register). Only the last
// byte of a frame waits on m_tready; other bytes drain regardless of output
// stalls. Reset clears frame state immediately, no clearing pass.
// ----------------------------------------------------------------------------
module modbus_fc4_response_checker #(
    parameter int MAX_FRAME = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mfc4_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // rx_byte
    input  logic                            s_tlast,   // end_of_frame
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [39:0]                     m_tdata    // status, version_word, type_word
);
    import mfc4_pkg::*;

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         out_valid_reg, out_valid_next;
    mfc4_result_t out_reg;
    mfc4_result_t result;
    logic [7:0]   slave_address;
    logic         out_free;
    logic         step;

    mfc4_apb_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .slave_address (slave_address)
    );

    mfc4_frame_check #(
        .MAX_FRAME (MAX_FRAME)
    ) u_frame (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .rx_byte       (in_byte_reg),
        .last          (in_last_reg),
        .slave_address (slave_address),
        .result        (result)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || step;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && in_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (step && in_last_reg)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_reg.type_word, out_reg.version_word, out_reg.status};

    a_fail_zero_words: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status != ST_OK
            |-> out_reg.version_word == 16'h0000 && out_reg.type_word == 16'h0000)
        else $error("words not zero on failed verdict");

    a_mid_byte_drains: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !in_last_reg |-> step)
        else $error("mid-frame byte held back");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.status <= ST_CRC)
        else $error("status code out of range");

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Modbus function 4 response checker. Frames are
// built from well-formed responses with random register words, some broken
// on purpose (header faults, bad CRC, short, overlong) and some plain noise.
// A bit-accurate predictor follows every accepted byte and queues the verdict
// for each frame; the monitor compares each returned verdict field by field.
// ----------------------------------------------------------------------------
module testbench;

    import mfc4_pkg::*;

    localparam int FRAME_LIMIT   = 16;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [APB_ADDR_W-1:0] SLAVE_ADDR_OFS = APB_ADDR_W'(4 * REG_IDX_SLAVE_ADDR);

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       eof;
    } rx_req_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;   // rx_byte[7:0]
    logic                  s_tlast  = 1'b0; // end_of_frame
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [39:0]           m_tdata;         // status[2:0], version_word[18:3], type_word[34:19]

    modbus_fc4_response_checker #(
        .MAX_FRAME (FRAME_LIMIT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stimulus and prediction state
    rx_req_t      rx_pending[$];
    logic [7:0]   frame_buf[$];
    mfc4_result_t verdict_queue[$];

    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;
    logic         hold_go        = 1'b0;
    int           hold_left      = 0;
    int           mismatch_count = 0;
    int           frames_done    = 0;
    int           bytes_taken_total = 0;
    int           status_seen[6];
    int           stall_cycles   = 0;

    logic [7:0]   cfg_slave   = SLAVE_ADDR_RST;
    logic [15:0]  crc_run     = CRC_INIT;
    int unsigned  frame_pos   = 0;
    logic [7:0]   lag_lo      = '0;
    logic [7:0]   lag_hi      = '0;
    logic [2:0]   hdr_fault   = ST_OK;
    logic [15:0]  ver_cap     = '0;
    logic [15:0]  typ_cap     = '0;

    function automatic logic [15:0] crc16_modbus_fold(input logic [15:0] acc,
                                                      input logic [7:0]  data);
        logic [15:0] r;
        r = acc ^ {8'h00, data};
        repeat (8)
        begin
            r = (r >> 1) ^ (r[0] ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    task automatic clear_frame_state();
        crc_run   = CRC_INIT;
        frame_pos = 0;
        lag_lo    = '0;
        lag_hi    = '0;
        hdr_fault = ST_OK;
        ver_cap   = '0;
        typ_cap   = '0;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        mfc4_result_t v;
        if (frame_pos < FRAME_LIMIT)
        begin
            // the last two accepted bytes stay out of the CRC
            if (frame_pos >= 2)
                crc_run = crc16_modbus_fold(crc_run, lag_lo);
            lag_lo = lag_hi;
            lag_hi = b;
            case (frame_pos)
                0: if (b != cfg_slave && hdr_fault == ST_OK) hdr_fault = ST_ADDR;
                1: if (b != FC_READ_INPUT && hdr_fault == ST_OK) hdr_fault = ST_FUNC;
                2: if (b != EXPECTED_COUNT && hdr_fault == ST_OK) hdr_fault = ST_COUNT;
                3: ver_cap = {b, 8'h00};
                4: ver_cap[7:0] = b;
                5: typ_cap = {b, 8'h00};
                6: typ_cap[7:0] = b;
                default: ;
            endcase
            frame_pos = frame_pos + 1;
        end
        if (last)
        begin
            if (frame_pos < MIN_FRAME)
                v.status = ST_SHORT;
            else if (hdr_fault != ST_OK)
                v.status = hdr_fault;
            else
                v.status = ({lag_hi, lag_lo} == crc_run) ? ST_OK : ST_CRC;
            v.version_word = (v.status == ST_OK) ? ver_cap : 16'h0000;
            v.type_word    = (v.status == ST_OK) ? typ_cap : 16'h0000;
            verdict_queue.push_back(v);
            status_seen[v.status]++;
            frames_done++;
            clear_frame_state();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h (frame %0d)",
                 what, got, want, frames_done);
        mismatch_count++;
    endtask

    // Driver
    always @(posedge clk)
    begin : drive_rx
        rx_req_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = rx_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.rx_byte;
                s_tlast  <= nxt.eof;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Long output hold-off
    always @(posedge clk)
    begin
        if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= (hold_left == 0) && !hold_go &&
                        ($urandom_range(99) >= recv_idle_pct);
    end

    // Input monitor feeds the predictor
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_byte(s_tdata, s_tlast);
            bytes_taken_total++;
        end
    end

    // Verdict monitor
    always @(posedge clk)
    begin : check_verdict
        mfc4_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_queue.size() == 0)
                report_mismatch("verdict with none pending", {13'h0, m_tdata[2:0]}, 16'h0);
            else
            begin
                want = verdict_queue.pop_front();
                if (m_tdata[2:0] != want.status)
                    report_mismatch("status", {13'h0, m_tdata[2:0]}, {13'h0, want.status});
                if (m_tdata[18:3] != want.version_word)
                    report_mismatch("version_word", m_tdata[18:3], want.version_word);
                if (m_tdata[34:19] != want.type_word)
                    report_mismatch("type_word", m_tdata[34:19], want.type_word);
                if (m_tdata[39:35] != 5'h00)
                    report_mismatch("tdata padding", {11'h0, m_tdata[39:35]}, 16'h0);
            end
        end
    end

    // Watchdog: cycles with no request of any kind
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_MAX)
            begin
                $display("timeout: no request for %0d cycles", stall_cycles);
                $display("modbus_fc4_response_checker regression: fail");
                $finish;
            end
        end
    end

    task automatic apb_write_slave(input logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SLAVE_ADDR_OFS;
        pwdata  <= {24'h000000, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        cfg_slave = value;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (rx_pending.size() != 0 || s_tvalid || verdict_queue.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic build_response(input logic [7:0] addr, input logic [7:0] fc,
                                  input logic [7:0] cnt, input logic [15:0] ver,
                                  input logic [15:0] typ, input int extra,
                                  input bit crc_good);
        logic [15:0] crc;
        frame_buf.delete();
        frame_buf.push_back(addr);
        frame_buf.push_back(fc);
        frame_buf.push_back(cnt);
        frame_buf.push_back(ver[15:8]);
        frame_buf.push_back(ver[7:0]);
        frame_buf.push_back(typ[15:8]);
        frame_buf.push_back(typ[7:0]);
        repeat (extra) frame_buf.push_back(8'($urandom_range(255)));
        crc = CRC_INIT;
        foreach (frame_buf[i])
            crc = crc16_modbus_fold(crc, frame_buf[i]);
        if (!crc_good)
            crc = crc ^ 16'($urandom_range(1, 65535));
        frame_buf.push_back(crc[7:0]);
        frame_buf.push_back(crc[15:8]);
    endtask

    task automatic send_frame();
        rx_req_t r;
        foreach (frame_buf[i])
        begin
            r.rx_byte = frame_buf[i];
            r.eof     = (i == frame_buf.size() - 1);
            rx_pending.push_back(r);
        end
    endtask

    task automatic add_junk(input int n);
        repeat (n) frame_buf.push_back(8'($urandom_range(255)));
    endtask

    task automatic gen_random_frame();
        int          pick;
        int          extra;
        int          len;
        logic [15:0] ver;
        logic [15:0] typ;
        pick  = $urandom_range(99);
        extra = ($urandom_range(3) == 0) ? $urandom_range(1, 7) : 0;
        ver   = 16'($urandom_range(65535));
        typ   = 16'($urandom_range(65535));
        if (pick < 55)
            build_response(cfg_slave, FC_READ_INPUT, EXPECTED_COUNT, ver, typ, extra, 1'b1);
        else if (pick < 65)
            build_response(cfg_slave, FC_READ_INPUT, EXPECTED_COUNT, ver, typ, extra, 1'b0);
        else if (pick < 72)
            build_response(cfg_slave ^ 8'($urandom_range(1, 255)),
                           ($urandom_range(1) != 0) ? FC_READ_INPUT : 8'($urandom_range(255)),
                           EXPECTED_COUNT, ver, typ, extra, 1'b1);
        else if (pick < 78)
            build_response(cfg_slave, FC_READ_INPUT ^ 8'($urandom_range(1, 255)),
                           ($urandom_range(1) != 0) ? EXPECTED_COUNT : 8'($urandom_range(255)),
                           ver, typ, extra, 1'b1);
        else if (pick < 84)
            build_response(cfg_slave, FC_READ_INPUT, EXPECTED_COUNT ^ 8'($urandom_range(1, 255)),
                           ver, typ, extra, $urandom_range(1) != 0);
        else if (pick < 88)
        begin
            // truncated response, may still carry a valid header
            build_response(cfg_slave, FC_READ_INPUT, EXPECTED_COUNT, ver, typ, 0, 1'b1);
            len = $urandom_range(1, MIN_FRAME - 1);
            frame_buf = frame_buf[0:len-1];
        end
        else if (pick < 94)
        begin
            // fills the frame limit exactly, tail is dropped by the block
            build_response(cfg_slave, FC_READ_INPUT, EXPECTED_COUNT, ver, typ,
                           FRAME_LIMIT - 9, $urandom_range(3) != 0);
            add_junk($urandom_range(1, 6));
        end
        else
        begin
            frame_buf.delete();
            add_junk($urandom_range(1, 20));
        end
    endtask

    task automatic run_phase(input logic [7:0] slave, input int send_pct,
                             input int recv_pct, input int budget, input bit long_hold);
        int queued;
        apb_write_slave(slave);
        @(posedge clk);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
        @(negedge clk);
        queued = 0;
        while (queued < budget)
        begin
            gen_random_frame();
            queued += frame_buf.size();
            send_frame();
        end
        if (long_hold)
        begin
            @(posedge clk);
            hold_go <= 1'b1;
            @(posedge clk);
            hold_go <= 1'b0;
        end
        wait_drained();
    endtask

    task automatic run_directed();
        build_response(cfg_slave, FC_READ_INPUT, EXPECTED_COUNT, 16'h0000, 16'h0000, 0, 1'b1);
        send_frame();
        build_response(cfg_slave, FC_READ_INPUT, EXPECTED_COUNT, 16'hFFFF, 16'hFFFF, 0, 1'b1);
        send_frame();
        // single byte, then one short of the minimum
        frame_buf.delete();
        frame_buf.push_back(cfg_slave);
        send_frame();
        build_response(cfg_slave, FC_READ_INPUT, EXPECTED_COUNT, 16'h1234, 16'h5678, 0, 1'b1);
        frame_buf = frame_buf[0:MIN_FRAME-2];
        send_frame();
        build_response(8'h00, FC_READ_INPUT, EXPECTED_COUNT, 16'hA5A5, 16'h5A5A, 0, 1'b1);
        send_frame();
        build_response(cfg_slave, 8'h03, EXPECTED_COUNT, 16'h0102, 16'h0304, 0, 1'b1);
        send_frame();
        build_response(cfg_slave, FC_READ_INPUT, 8'h02, 16'h0102, 16'h0304, 0, 1'b1);
        send_frame();
        // several header faults: the first one wins
        build_response(8'hFF, 8'h00, 8'hFF, 16'h0102, 16'h0304, 0, 1'b1);
        send_frame();
        build_response(cfg_slave, 8'hFF, 8'h00, 16'h0102, 16'h0304, 0, 1'b1);
        send_frame();
        build_response(cfg_slave, FC_READ_INPUT, EXPECTED_COUNT, 16'hBEEF, 16'hCAFE, 0, 1'b0);
        send_frame();
        build_response(cfg_slave, FC_READ_INPUT, EXPECTED_COUNT, 16'h8001, 16'h7FFE,
                       FRAME_LIMIT - 9, 1'b1);
        send_frame();
        // overlong: good CRC inside the limit, junk after it
        build_response(cfg_slave, FC_READ_INPUT, EXPECTED_COUNT, 16'h00FF, 16'hFF00,
                       FRAME_LIMIT - 9, 1'b1);
        add_junk(3);
        send_frame();
        build_response(cfg_slave, FC_READ_INPUT, EXPECTED_COUNT, 16'h00FF, 16'hFF00,
                       FRAME_LIMIT - 8, 1'b1);
        send_frame();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // reset value of the slave address is used first
        run_directed();
        wait_drained();
        run_phase(8'h00, 0, 0, 280, 1'b0);
        run_phase(8'hFF, 51, 0, 280, 1'b0);
        run_phase(8'($urandom_range(255)), 0, 51, 280, 1'b1);
        run_phase(8'($urandom_range(255)), 16, 16, 280, 1'b0);
        $display("covered %0d frames, %0d bytes: reset, zero, all-ones and random slave addresses",
                 frames_done, bytes_taken_total);
        $display("verdicts ok %0d short %0d addr %0d func %0d count %0d crc %0d",
                 status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_ADDR],
                 status_seen[ST_FUNC], status_seen[ST_COUNT], status_seen[ST_CRC]);
        if (mismatch_count == 0 && verdict_queue.size() == 0)
            $display("modbus_fc4_response_checker regression: pass");
        else
            $display("modbus_fc4_response_checker regression: fail");
        $finish;
    end

endmodule
